// ----- rtl/positional_pid_controller_core_assert.svh -----
// Assertion macros for the positional PID controller core.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef POSITIONAL_PID_CONTROLLER_CORE_ASSERT_SVH
`define POSITIONAL_PID_CONTROLLER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define PPC_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define PPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/ppid_pkg.sv -----
// Package for the positional PID controller: codes, command bus types, helpers.
// Used by the controller, the datapath and the top level.
package ppid_pkg;

    localparam int DIV_STEPS = 48;
    localparam int CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_FLOOR    = 3'd3;
    localparam logic [2:0] REG_CEILING  = 3'd4;
    localparam logic [2:0] REG_STEP_LIM = 3'd5;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    typedef enum logic [2:0] {
        MUL_P = 3'd0,
        MUL_I = 3'd1,
        MUL_D = 3'd2,
        MUL_H = 3'd3,
        MUL_L = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    load;
        mul_op_t mul_op;
        logic    st_p;
        logic    st_um;
        logic    st_x;
        logic    st_a;
        logic    acc_upd;
        logic    div_step;
        logic    emit;
    } ppid_cmd_t;

    typedef struct packed {
        logic out_free;
    } ppid_stat_t;

    // Saturate a 52-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [51:0] lo;
        logic signed [51:0] hi;
        lo = 52'(signed'(32'sh8000_0000));
        hi = 52'(signed'(32'sh7fff_ffff));
        if (v < lo)
            return 32'sh8000_0000;
        else if (v > hi)
            return 32'sh7fff_ffff;
        else
            return v[31:0];
    endfunction

endpackage

// ----- rtl/positional_pid_controller_core.sv -----
// Top level of the positional PID controller core.
// Depends on ppid_pkg, ppid_ctrl, ppid_dp and the assertion macro header.
//
// Usage:
//   Slave channel s_*: one item per command; s_tuser carries the command
//   (sample, clear history, load integral). Master channel m_*: one item
//   per sample command, carrying drive and the saturated P and I terms.
//   Configuration: cfg_we/cfg_addr/cfg_data write a register;
//   write only while no item is in progress.
//   Sequence: after acceptance a sample makes five passes through the
//   shared 33x32 multiplier, one integral update, the steps of the
//   one-bit-per-cycle restoring divider for the derivative, and then
//   registers the result.
//   Clear and load complete in the accepting cycle; the next item can
//   follow in the next cycle. A new sample is accepted in the cycle after
//   the previous result is registered, not while one is in progress.
//   The output register holds a result while m_tready is low; the next
//   sample computes meanwhile and waits at its end until the register frees.
//   Reset: gains zero, limits fully open, step limit 100000, integral and
//   last error zero, next sample treated as first (no derivative).
module positional_pid_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // error_value[31:0], elapsed_ticks[55:32],
                                   // integral_preset[87:56]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // drive[31:0], proportional_term[63:32],
                                   // integral_term[95:64]
);

`include "positional_pid_controller_core_assert.svh"

    ppid_pkg::ppid_cmd_t  cmd;
    ppid_pkg::ppid_stat_t stat;

    ppid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // A sample blocks the input until its result is registered
    `PPC_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && s_tuser == ppid_pkg::CMD_SAMPLE, !s_tready, "input accepted while a sample is in progress")
    // A registered result is presented on the next cycle
    `PPC_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "result emitted but not presented")
    // At most one multiplier result store per cycle
    `PPC_ASSERT_NOW(a_one_store, $onehot0({cmd.st_p, cmd.st_um, cmd.st_x, cmd.st_a, cmd.acc_upd}), "overlapping datapath stores")

endmodule

// ----- rtl/ppid_ctrl.sv -----
// Sequencer for the positional PID controller: accepts items and steps the datapath.
// Depends on ppid_pkg.
module ppid_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_cmd,
    output logic                 in_ready,
    input  ppid_pkg::ppid_stat_t stat,
    output ppid_pkg::ppid_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MP   = 9'b000000010,
        ST_MI   = 9'b000000100,
        ST_MD   = 9'b000001000,
        ST_MH   = 9'b000010000,
        ST_ML   = 9'b000100000,
        ST_ACC  = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [ppid_pkg::CNT_W-1:0]   cnt_reg;
    logic [ppid_pkg::CNT_W-1:0]   cnt_next;
    logic                         accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Accept items, then sequence the multiplier passes, integral update, divide and output
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_op   = ppid_pkg::MUL_P;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        ppid_pkg::CMD_SAMPLE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_MP;
                        end
                        ppid_pkg::CMD_CLEAR: cmd.clear = 1'b1;
                        ppid_pkg::CMD_LOAD:  cmd.load  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_MP:
            begin
                cmd.mul_op = ppid_pkg::MUL_P;
                state_next = ST_MI;
            end
            ST_MI:
            begin
                cmd.st_p   = 1'b1;
                cmd.mul_op = ppid_pkg::MUL_I;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.st_um  = 1'b1;
                cmd.mul_op = ppid_pkg::MUL_D;
                state_next = ST_MH;
            end
            ST_MH:
            begin
                cmd.st_x   = 1'b1;
                cmd.mul_op = ppid_pkg::MUL_H;
                state_next = ST_ML;
            end
            ST_ML:
            begin
                cmd.st_a   = 1'b1;
                cmd.mul_op = ppid_pkg::MUL_L;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_upd = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ppid_pkg::CNT_W'(ppid_pkg::DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/ppid_dp.sv -----
// Datapath for the positional PID controller: config registers, history state,
// shared multiplier, restoring divider and output register. Depends on ppid_pkg.
module ppid_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_addr,
    input  logic [31:0]          cfg_data,
    input  logic [87:0]          in_data,
    input  ppid_pkg::ppid_cmd_t  cmd,
    output ppid_pkg::ppid_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [95:0]          out_data
);

    localparam logic [47:0] CAP = 48'h8000_0000_0000;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, floor_reg, ceil_reg;
    logic [23:0]        step_lim_reg;
    logic signed [47:0] acc_reg;
    logic signed [31:0] last_err_reg;
    logic               first_reg;

    logic signed [31:0] e_reg;
    logic [23:0]        dt_reg;
    logic signed [32:0] diff_reg;
    logic               first_q_reg;

    logic [63:0]        prod_reg;
    logic signed [47:0] p_reg;
    logic [62:0]        um_reg;
    logic [54:0]        a_reg;
    logic               d_neg_reg;
    logic [23:0]        rem_reg;
    logic [47:0]        q_reg;
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;

    logic signed [31:0] in_err;
    logic [23:0]        in_ticks;
    logic signed [31:0] in_preset;
    logic [23:0]        lim;
    logic [23:0]        dt_next;
    logic [31:0]        e_mag, kp_mag, ki_mag, kd_mag;
    logic [32:0]        diff_mag;
    logic               p_neg, i_neg;
    logic [32:0]        op_a;
    logic [31:0]        op_b;
    logic [87:0]        total;
    logic [71:0]        m_full;
    logic [47:0]        m_int;
    logic signed [48:0] inc;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_next;
    logic [24:0]        trial;
    logic signed [49:0] d_val;
    logic signed [51:0] sum;
    logic signed [51:0] sum_hi;
    logic signed [31:0] drive;

    assign in_err    = in_data[31:0];
    assign in_ticks  = in_data[55:32];
    assign in_preset = in_data[87:56];

    // Clamp the elapsed ticks to 1..step_limit (a step limit of zero counts as one)
    always_comb
    begin
        lim     = (step_lim_reg == 24'd0) ? 24'd1 : step_lim_reg;
        dt_next = (in_ticks == 24'd0) ? 24'd1 : in_ticks;
        if (dt_next > lim)
            dt_next = lim;
    end

    // Magnitudes and signs of the operands
    assign e_mag    = e_reg[31] ? 32'(-e_reg) : 32'(e_reg);
    assign kp_mag   = gain_p_reg[31] ? 32'(-gain_p_reg) : 32'(gain_p_reg);
    assign ki_mag   = gain_i_reg[31] ? 32'(-gain_i_reg) : 32'(gain_i_reg);
    assign kd_mag   = gain_d_reg[31] ? 32'(-gain_d_reg) : 32'(gain_d_reg);
    assign diff_mag = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
    assign p_neg    = gain_p_reg[31] ^ e_reg[31];
    assign i_neg    = gain_i_reg[31] ^ e_reg[31];

    // Select the operands of the shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            ppid_pkg::MUL_P:
            begin
                op_a = {1'b0, kp_mag};
                op_b = e_mag;
            end
            ppid_pkg::MUL_I:
            begin
                op_a = {1'b0, ki_mag};
                op_b = e_mag;
            end
            ppid_pkg::MUL_D:
            begin
                op_a = diff_mag;
                op_b = kd_mag;
            end
            ppid_pkg::MUL_H:
            begin
                op_a = {2'b00, um_reg[62:32]};
                op_b = {8'd0, dt_reg};
            end
            ppid_pkg::MUL_L:
            begin
                op_a = {1'b0, um_reg[31:0]};
                op_b = {8'd0, dt_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Integral increment, saturated, then added to the accumulator
    always_comb
    begin
        total  = {1'b0, a_reg, 32'd0} + 88'(prod_reg[55:0]);
        m_full = total[87:16];
        m_int  = (m_full >= 72'(CAP)) ? CAP : m_full[47:0];
        if (i_neg)
            inc = -signed'({1'b0, m_int});
        else if (m_int == CAP)
            inc = signed'({1'b0, CAP - 48'd1});
        else
            inc = signed'({1'b0, m_int});
        acc_sum = 49'(acc_reg) + inc;
        if (acc_sum < -49'sd140737488355328)
            acc_next = 48'sh8000_0000_0000;
        else if (acc_sum > 49'sd140737488355327)
            acc_next = 48'sh7fff_ffff_ffff;
        else
            acc_next = acc_sum[47:0];
    end

    assign trial = {rem_reg, q_reg[47]};

    // Drive sum and clamp: ceiling first, then floor
    always_comb
    begin
        if (first_q_reg)
            d_val = '0;
        else if (d_neg_reg)
            d_val = -signed'({2'b00, q_reg});
        else
            d_val = signed'({2'b00, q_reg});
        sum    = 52'(p_reg) + 52'(acc_reg) + 52'(d_val);
        sum_hi = (sum > 52'(ceil_reg)) ? 52'(ceil_reg) : sum;
        drive  = (sum_hi < 52'(floor_reg)) ? floor_reg : sum_hi[31:0];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            floor_reg    <= 32'sh8000_0000;
            ceil_reg     <= 32'sh7fff_ffff;
            step_lim_reg <= 24'd100000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ppid_pkg::REG_GAIN_P:   gain_p_reg   <= cfg_data;
                ppid_pkg::REG_GAIN_I:   gain_i_reg   <= cfg_data;
                ppid_pkg::REG_GAIN_D:   gain_d_reg   <= cfg_data;
                ppid_pkg::REG_FLOOR:    floor_reg    <= cfg_data;
                ppid_pkg::REG_CEILING:  ceil_reg     <= cfg_data;
                ppid_pkg::REG_STEP_LIM: step_lim_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // History state: clear, load, capture and integral update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            last_err_reg <= '0;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (cmd.clear)
            begin
                acc_reg      <= '0;
                last_err_reg <= '0;
                first_reg    <= 1'b1;
            end
            if (cmd.load)
                acc_reg <= 48'(in_preset);
            if (cmd.capture)
            begin
                last_err_reg <= in_err;
                first_reg    <= 1'b0;
            end
            if (cmd.acc_upd)
                acc_reg <= acc_next;
        end
    end

    // Working registers of one sample
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            e_reg       <= in_err;
            dt_reg      <= dt_next;
            diff_reg    <= 33'(in_err) - 33'(last_err_reg);
            first_q_reg <= first_reg;
        end
        prod_reg <= 64'(op_a) * 64'(op_b);
        if (cmd.st_p)
            p_reg <= p_neg ? -signed'({1'b0, prod_reg[62:16]}) : signed'({1'b0, prod_reg[62:16]});
        if (cmd.st_um)
            um_reg <= prod_reg[62:0];
        if (cmd.st_x)
        begin
            q_reg     <= prod_reg[63:16];
            d_neg_reg <= gain_d_reg[31] ^ diff_reg[32];
            rem_reg   <= '0;
        end
        if (cmd.st_a)
            a_reg <= prod_reg[54:0];
        // One quotient bit per step
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, dt_reg})
            begin
                rem_reg <= 24'(trial - {1'b0, dt_reg});
                q_reg   <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[23:0];
                q_reg   <= {q_reg[46:0], 1'b0};
            end
        end
        if (cmd.emit)
            out_data_reg <= {ppid_pkg::sat32(52'(acc_reg)), ppid_pkg::sat32(52'(p_reg)), drive};
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule
